FILE: hw/rtl/npc_pkg.sv
// Package: shared types and constants for the nearest palette color block.
`timescale 1ns / 1ps
`default_nettype none
package npc_pkg;

    localparam int PALETTE_SIZE_DEF = 24;
    localparam int IDX_W  = 5;
    localparam int COL_W  = 8;
    localparam int DIST_W = 20;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [9:0] RED_BASE  = 10'd512;
    localparam logic [9:0] BLUE_BASE = 10'd767;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
        logic [IDX_W-1:0]  best_idx;
        logic [23:0]       best_rgb;
        logic [DIST_W-1:0] best_d;
    } t_item;

    function automatic logic [COL_W-1:0] abs_diff(input logic [COL_W-1:0] a,
                                                  input logic [COL_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/npc_cell.sv
// Chain cell: holds one palette entry, updates the running best of a passing query.
`timescale 1ns / 1ps
`default_nettype none
module npc_cell import npc_pkg::*; #(
    parameter int CELL_ID = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_item      o_item
);

    logic [23:0] r_entry;

    logic  r_v1, r_v2, r_v3, r_v4;
    t_item r_it1, r_it2, r_it3, r_it4;
    logic [23:0] r_e1, r_e2, r_e3;

    logic [COL_W-1:0] r_adr, r_adg, r_adb, r_rm;
    logic [15:0]      r_sr, r_sg, r_sb;
    logic [9:0]       r_wr, r_wb;
    logic [17:0]      r_tr, r_tg, r_tb;

    logic             wr_hit;
    logic [8:0]       rsum;
    logic [25:0]      prod_r, prod_b;
    logic [DIST_W-1:0] sum_d;
    t_item            n_it4;

    assign wr_hit = i_valid && (i_item.op == OP_WRITE) &&
                    ({{(32-IDX_W){1'b0}}, i_item.idx} == 32'(CELL_ID));
    assign rsum   = {1'b0, i_item.red} + {1'b0, r_entry[23:16]};
    assign prod_r = {16'd0, r_wr} * {10'd0, r_sr};
    assign prod_b = {16'd0, r_wb} * {10'd0, r_sb};
    assign sum_d  = {2'b00, r_tr} + {2'b00, r_tg} + {2'b00, r_tb};

    always_comb begin
        n_it4 = r_it3;
        if (r_it3.op == OP_QUERY && sum_d < r_it3.best_d) begin
            n_it4.best_d   = sum_d;
            n_it4.best_idx = IDX_W'(CELL_ID);
            n_it4.best_rgb = r_e3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (wr_hit) begin
                r_entry <= {i_item.red, i_item.green, i_item.blue};
            end
            // stage 1: differences and mean red
            r_it1 <= i_item;
            r_e1  <= r_entry;
            r_adr <= abs_diff(i_item.red,   r_entry[23:16]);
            r_adg <= abs_diff(i_item.green, r_entry[15:8]);
            r_adb <= abs_diff(i_item.blue,  r_entry[7:0]);
            r_rm  <= rsum[8:1];
            // stage 2: squares and weights
            r_it2 <= r_it1;
            r_e2  <= r_e1;
            r_sr  <= {8'd0, r_adr} * {8'd0, r_adr};
            r_sg  <= {8'd0, r_adg} * {8'd0, r_adg};
            r_sb  <= {8'd0, r_adb} * {8'd0, r_adb};
            r_wr  <= RED_BASE + {2'b00, r_rm};
            r_wb  <= BLUE_BASE - {2'b00, r_rm};
            // stage 3: weighted terms
            r_it3 <= r_it2;
            r_e3  <= r_e2;
            r_tr  <= prod_r[25:8];
            r_tg  <= {r_sg, 2'b00};
            r_tb  <= prod_b[25:8];
            // stage 4: sum and compare
            r_it4 <= n_it4;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_it4;

endmodule
`default_nettype wire

FILE: hw/rtl/nearest_palette_color_top.sv
// Top level: redmean nearest palette color search over a chain of entry cells.
// Every item, write or query, walks the whole chain of cells.
// Throughput: one transfer per cycle while the sink does not hold the output.
// Output held by the sink stalls the whole chain and the input.
// Reset clears pipeline valid state only; palette entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module nearest_palette_color_top import npc_pkg::*; #(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [4:0] entry_index, [12:5] red, [20:13] green, [28:21] blue, [31:29] zero
    input  wire logic [31:0] i_s_axis_tdata,
    // [0] operation
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [4:0] nearest_index, [12:5] nearest_red, [20:13] nearest_green,
    // [28:21] nearest_blue, [48:29] best_distance, [55:49] zero
    output logic [55:0]      o_m_axis_tdata
);

    logic  en;
    logic  w_valid [0:PALETTE_SIZE];
    t_item w_item  [0:PALETTE_SIZE];

    logic        r_out_valid;
    logic [48:0] r_out_data;

    assign en = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign w_valid[0]         = i_s_axis_tvalid;
    assign w_item[0].op       = i_s_axis_tuser;
    assign w_item[0].idx      = i_s_axis_tdata[4:0];
    assign w_item[0].red      = i_s_axis_tdata[12:5];
    assign w_item[0].green    = i_s_axis_tdata[20:13];
    assign w_item[0].blue     = i_s_axis_tdata[28:21];
    assign w_item[0].best_idx = '0;
    assign w_item[0].best_rgb = '0;
    assign w_item[0].best_d   = '1;

    for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
        npc_cell #(
            .CELL_ID (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_valid[PALETTE_SIZE] && (w_item[PALETTE_SIZE].op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {w_item[PALETTE_SIZE].best_d,
                           w_item[PALETTE_SIZE].best_rgb[7:0],
                           w_item[PALETTE_SIZE].best_rgb[15:8],
                           w_item[PALETTE_SIZE].best_rgb[23:16],
                           w_item[PALETTE_SIZE].best_idx};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_data};

endmodule
`default_nettype wire
